### sv/firc_pkg.sv
package firc_pkg;

  // fixed field widths
  localparam int TC_W  = 7;
  localparam int CMD_W = 2;
  localparam int IDX_W = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOAD,
    ST_CLR,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic clr_step;
    logic clr_coef;
    logic write_sample;
    logic issue;
    logic round;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

### sv/firc_ram.sv
module firc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/firc_ctrl.sv
module firc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [firc_pkg::CMD_W-1:0] cmd,
  input  firc_pkg::dp_status_t    status,
  output logic                    in_ready,
  output firc_pkg::ctrl_cmd_t     ctrl
);

  firc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= firc_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      firc_pkg::ST_INIT: begin
        if (status.sweep_last) state_next = firc_pkg::ST_IDLE;
      end
      firc_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            firc_pkg::CMD_FILTER: state_next = firc_pkg::ST_WRITE;
            firc_pkg::CMD_LOAD:   state_next = firc_pkg::ST_LOAD;
            firc_pkg::CMD_CLEAR:  state_next = firc_pkg::ST_CLR;
            default:              state_next = firc_pkg::ST_IDLE;
          endcase
        end
      end
      firc_pkg::ST_LOAD:  state_next = firc_pkg::ST_IDLE;
      firc_pkg::ST_CLR: begin
        if (status.sweep_last) state_next = firc_pkg::ST_IDLE;
      end
      firc_pkg::ST_WRITE: state_next = firc_pkg::ST_MAC;
      firc_pkg::ST_MAC: begin
        if (status.last_tap) state_next = firc_pkg::ST_DRAIN;
      end
      firc_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) state_next = firc_pkg::ST_ROUND;
      end
      firc_pkg::ST_ROUND: state_next = firc_pkg::ST_PUSH;
      firc_pkg::ST_PUSH: begin
        if (status.out_free) state_next = firc_pkg::ST_IDLE;
      end
      default: state_next = firc_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    case (state)
      firc_pkg::ST_INIT: begin
        ctrl.clr_step = 1'b1;
        ctrl.clr_coef = 1'b1;
      end
      firc_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl.capture = in_valid;
      end
      firc_pkg::ST_LOAD:  ctrl.load = 1'b1;
      firc_pkg::ST_CLR:   ctrl.clr_step = 1'b1;
      firc_pkg::ST_WRITE: ctrl.write_sample = 1'b1;
      firc_pkg::ST_MAC:   ctrl.issue = 1'b1;
      firc_pkg::ST_ROUND: ctrl.round = 1'b1;
      firc_pkg::ST_PUSH:  ctrl.push = status.out_free;
      default: ;
    endcase
  end

endmodule

### sv/firc_dp.sv
module firc_dp #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  firc_pkg::ctrl_cmd_t         ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [firc_pkg::IDX_W-1:0]  tap_index,
  input  logic signed [COEF_BITS-1:0] tap_value,
  input  logic                        cfg_we,
  input  logic [firc_pkg::TC_W-1:0]   cfg_data,
  output firc_pkg::dp_status_t        status,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                        saturated,
  output logic                        out_valid,
  input  logic                        out_ready
);

  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int NW     = AW + 1;
  localparam int CW     = (firc_pkg::TC_W > NW) ? firc_pkg::TC_W : NW;
  localparam int PW     = SAMPLE_BITS + COEF_BITS;
  localparam int FULL_W = PW + $clog2(MAX_TAPS + 1) + 1;
  localparam int ACC_W  = (FULL_W > 64) ? 64 : FULL_W;
  localparam int SH     = COEF_BITS - 2;
  localparam int VW     = ACC_W - SH;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SH - 1);
  localparam logic [AW-1:0]    LAST = AW'(MAX_TAPS - 1);

  logic [firc_pkg::TC_W-1:0] tap_count;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [firc_pkg::IDX_W-1:0]  idx_q;
  logic signed [COEF_BITS-1:0] val_q;

  logic [AW-1:0] tap;
  logic [AW-1:0] hptr;
  logic [AW-1:0] wp;
  logic [NW-1:0] n;

  logic rd_v1, rd_v2;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0]        rnd;

  logic [CW-1:0] tc_w, max_w, n_clamp;
  logic          load_ok;

  logic                 hist_we, coef_we;
  logic [AW-1:0]        hist_waddr, coef_waddr;
  logic [SAMPLE_BITS-1:0] hist_wdata, hist_rd;
  logic [COEF_BITS-1:0]   coef_wdata, coef_rd;

  logic [VW-1:0]            v;
  logic [VW-SAMPLE_BITS:0]  upper;
  logic                     pos_ovf, neg_ovf;
  logic [SAMPLE_BITS-1:0]   y;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= firc_pkg::TC_W'(1);
    end else if (cfg_we) begin
      tap_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      sample_q <= sample_in;
      idx_q    <= tap_index;
      val_q    <= tap_value;
    end
  end

  // tap count of zero runs as one tap, above the depth as the full depth
  always_comb begin
    tc_w  = CW'(tap_count);
    max_w = CW'(MAX_TAPS);
    if (tc_w == '0) begin
      n_clamp = CW'(1);
    end else if (tc_w > max_w) begin
      n_clamp = max_w;
    end else begin
      n_clamp = tc_w;
    end
  end

  assign load_ok = 32'(idx_q) < 32'(MAX_TAPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
      wp  <= '0;
    end else begin
      if (ctrl.capture) begin
        tap <= '0;
      end else if (ctrl.clr_step || ctrl.issue) begin
        tap <= (tap == LAST) ? '0 : tap + AW'(1);
      end
      if (ctrl.clr_step) begin
        wp <= '0;
      end else if (ctrl.write_sample) begin
        wp <= (wp == '0) ? LAST : wp - AW'(1);
      end
    end
  end

  // history read pointer walks from the newest sample towards older ones
  always_ff @(posedge clk) begin
    if (ctrl.write_sample) begin
      hptr <= wp;
      n    <= NW'(n_clamp);
    end else if (ctrl.issue) begin
      hptr <= (hptr == LAST) ? '0 : hptr + AW'(1);
    end
  end

  always_comb begin
    hist_we    = ctrl.clr_step || ctrl.write_sample;
    hist_waddr = ctrl.write_sample ? wp : tap;
    hist_wdata = ctrl.write_sample ? sample_q : '0;
    coef_we    = (ctrl.clr_step && ctrl.clr_coef) || (ctrl.load && load_ok);
    coef_waddr = ctrl.load ? AW'(idx_q) : tap;
    coef_wdata = ctrl.load ? val_q : '0;
  end

  firc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hptr),
    .rdata (hist_rd)
  );

  firc_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (tap),
    .rdata (coef_rd)
  );

  // read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v1 <= 1'b0;
      rd_v2 <= 1'b0;
    end else begin
      rd_v1 <= ctrl.issue;
      rd_v2 <= rd_v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(coef_rd) * $signed(hist_rd);
    if (ctrl.write_sample) begin
      acc <= '0;
    end else if (rd_v2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctrl.round) begin
      rnd <= acc + HALF;
    end
  end

  // arithmetic shift is a plain select, then clip to the sample range
  always_comb begin
    v       = rnd[ACC_W-1:SH];
    upper   = v[VW-1:SAMPLE_BITS-1];
    pos_ovf = !v[VW-1] && (|upper);
    neg_ovf = v[VW-1] && !(&upper);
    if (pos_ovf) begin
      y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (neg_ovf) begin
      y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y = v[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      sample_out <= y;
      saturated  <= pos_ovf || neg_ovf;
    end
  end

  always_comb begin
    status.sweep_last = (tap == LAST);
    status.last_tap   = ({1'b0, tap} == n - NW'(1));
    status.pipe_busy  = rd_v1 || rd_v2;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

### sv/fir_filter_circular.sv
// channel   direction  transfer when            payload
// in        input      in_valid & in_ready      cmd, sample_in, tap_index, tap_value
// out       output     out_valid & out_ready    sample_out, saturated
// cfg       input      cfg_valid & cfg_ready    cfg_data (tap_count), always ready
//
// a filter item takes its transfer, a sample write and one shared multiply-accumulate
// per tap, n being tap_count held to 1..MAX_TAPS, then a drain of the read and
// multiply registers, round and output
// a load item writes one coefficient, a clear item sweeps the history to zero
// after reset both memories are swept to zero, in_ready low
// the output register frees the datapath: a waiting result blocks only the
// final push step of the next filter item
module fir_filter_circular #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [firc_pkg::CMD_W-1:0]    cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [firc_pkg::IDX_W-1:0]    tap_index,
  input  logic signed [COEF_BITS-1:0]   tap_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [firc_pkg::TC_W-1:0]     cfg_data
);

  firc_pkg::ctrl_cmd_t  ctrl;
  firc_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  firc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .status   (status),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  firc_dp #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sample_in  (sample_in),
    .tap_index  (tap_index),
    .tap_value  (tap_value),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .status     (status),
    .sample_out (sample_out),
    .saturated  (saturated),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  // no two datapath commands (memory operations, round, push) in one cycle
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.load, ctrl.clr_step, ctrl.write_sample, ctrl.issue, ctrl.round,
              ctrl.push}))
    else $error("overlapping datapath commands");

  // a new item never meets a busy multiply pipeline
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !status.pipe_busy)
    else $error("item accepted with products still in flight");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !ctrl.push)
    else $error("result pushed over a waiting result");

  // memory sweep runs before the first transfer
  a_init_sweep: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready)
    else $error("input ready before reset sweep");

endmodule

### test/firc_checker.sv
`timescale 1ns / 100ps

module firc_checker #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [firc_pkg::CMD_W-1:0]    cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [firc_pkg::IDX_W-1:0]    tap_index,
  input  logic signed [COEF_BITS-1:0]   tap_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          saturated,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [firc_pkg::TC_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            pending,
  output int                            compared
);

  localparam int FRAC = COEF_BITS - 2;
  localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          sat;
  } fir_out_t;

  logic signed [SAMPLE_BITS-1:0] hist [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef [MAX_TAPS];
  int                            wpos;
  int                            taps;
  fir_out_t                      expected_out [$];
  int                            errs = 0;
  int                            n_cmp = 0;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errs++;
  endtask

  // writes the sample into the ring, sums the taps, rounds and clips
  function automatic fir_out_t fir_predict(input logic signed [SAMPLE_BITS-1:0] smp);
    int n, k;
    logic signed [63:0] acc, c, h, y, hi, lo;
    fir_out_t r;
    n = taps;
    if (n == 0) n = 1;
    if (n > MAX_TAPS) n = MAX_TAPS;
    hist[AW'(wpos)] = smp;
    acc = '0;
    for (k = 0; k < n; k++) begin
      c = 64'(coef[AW'(k)]);
      h = 64'(hist[AW'((wpos + k) % MAX_TAPS)]);
      acc += c * h;
    end
    wpos = (wpos == 0) ? MAX_TAPS - 1 : wpos - 1;
    // round half up, then drop the coefficient fraction bits
    y  = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    r.sat = 1'b0;
    if (y > hi) begin
      y     = hi;
      r.sat = 1'b1;
    end else if (y < lo) begin
      y     = lo;
      r.sat = 1'b1;
    end
    r.value = y[SAMPLE_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    fir_out_t want;
    int       i;
    if (rst) begin
      for (i = 0; i < MAX_TAPS; i++) begin
        hist[AW'(i)] = '0;
        coef[AW'(i)] = '0;
      end
      wpos = 0;
      taps = 1;
      expected_out.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_out.size() == 0) begin
          report($sformatf("output transfer %0d/%0b with nothing outstanding",
                           sample_out, saturated));
        end else begin
          want = expected_out.pop_front();
          n_cmp++;
          if (sample_out !== want.value)
            report($sformatf("sample_out %0d, predicted %0d (output %0d)",
                             sample_out, want.value, n_cmp));
          if (saturated !== want.sat)
            report($sformatf("saturated %0b, predicted %0b (output %0d)",
                             saturated, want.sat, n_cmp));
        end
      end
      if (cfg_valid && cfg_ready) taps = int'(cfg_data);
      if (in_valid && in_ready) begin
        case (cmd)
          firc_pkg::CMD_FILTER: expected_out.push_back(fir_predict(sample_in));
          firc_pkg::CMD_LOAD:   coef[tap_index] = tap_value;
          firc_pkg::CMD_CLEAR: begin
            for (i = 0; i < MAX_TAPS; i++) hist[AW'(i)] = '0;
            wpos = 0;
          end
          default: ;
        endcase
      end
    end
    mismatches <= errs;
    pending    <= expected_out.size();
    compared   <= n_cmp;
  end

endmodule

### test/tb_fir_filter_circular.sv
`timescale 1ns / 100ps

module tb_fir_filter_circular;

  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 18;
  localparam logic [firc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int N_ITEMS     = 550;
  localparam int DRAIN_CYC   = MAX_TAPS + 16;
  localparam int HOLD_CYC    = 400;
  localparam int CYCLE_LIMIT = 600000;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [firc_pkg::CMD_W-1:0]    cmd;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [firc_pkg::IDX_W-1:0]    tap_index;
  logic signed [COEF_BITS-1:0]   tap_value;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [firc_pkg::TC_W-1:0]     cfg_data;

  logic calm;
  logic hold_req;
  int   mismatches, pending, compared;
  int   n_items, n_settings, cycles;

  fir_filter_circular #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sample_in (sample_in),
    .tap_index (tap_index),
    .tap_value (tap_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  firc_checker #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sample_in (sample_in),
    .tap_index (tap_index),
    .tap_value (tap_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending),
    .compared  (compared)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped after %0d cycles without finishing", cycles);
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int hold_left;
    bit hold_seen;
    out_ready = 1'b0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    logic [31:0]                   r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0:       s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1:       s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      default: s = r[SAMPLE_BITS-1:0];
    endcase
    return s;
  endfunction

  // modest gains half the time so long filters do not always clip
  function automatic logic signed [COEF_BITS-1:0] rand_coef();
    logic signed [COEF_BITS-1:0] c;
    logic [31:0]                 r;
    int                          t;
    r = $urandom();
    t = int'($urandom_range(0, 8191)) - 4096;
    case ($urandom_range(0, 7))
      0:       c = {1'b0, {(COEF_BITS-1){1'b1}}};
      1:       c = {1'b1, {(COEF_BITS-1){1'b0}}};
      2, 3:    c = r[COEF_BITS-1:0];
      default: c = t[COEF_BITS-1:0];
    endcase
    return c;
  endfunction

  function automatic logic [firc_pkg::IDX_W-1:0] rand_idx();
    int r;
    r = int'($urandom_range(0, MAX_TAPS - 1));
    return r[firc_pkg::IDX_W-1:0];
  endfunction

  task automatic push_item(input logic [firc_pkg::CMD_W-1:0] c,
                           input logic signed [SAMPLE_BITS-1:0] s,
                           input logic [firc_pkg::IDX_W-1:0] idx,
                           input logic signed [COEF_BITS-1:0] v);
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 72)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    sample_in <= s;
    tap_index <= idx;
    tap_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c != CMD_UNUSED) n_items++;
  endtask

  task automatic filter_item(input logic signed [SAMPLE_BITS-1:0] s);
    push_item(firc_pkg::CMD_FILTER, s, rand_idx(), rand_coef());
  endtask

  task automatic load_item(input int idx, input logic signed [COEF_BITS-1:0] v);
    push_item(firc_pkg::CMD_LOAD, rand_sample(), idx[firc_pkg::IDX_W-1:0], v);
  endtask

  task automatic clear_item();
    push_item(firc_pkg::CMD_CLEAR, rand_sample(), rand_idx(), rand_coef());
  endtask

  // nothing outstanding, then room for a clear or a long filter still running
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_taps(input int tc);
    cfg_valid <= 1'b1;
    cfg_data  <= tc[firc_pkg::TC_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int tc, r, phase;
    rst        = 1'b1;
    in_valid   = 1'b0;
    cmd        = firc_pkg::CMD_FILTER;
    sample_in  = '0;
    tap_index  = '0;
    tap_value  = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    n_items    = 0;
    n_settings = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // single tap out of reset: zero coefficients, then both clipping directions
    filter_item(16'sh7fff);
    load_item(0, 18'sh1ffff);
    filter_item(16'sh7fff);
    filter_item(-16'sh8000);
    load_item(0, -18'sh20000);
    filter_item(-16'sh8000);
    filter_item(16'sd1);
    push_item(CMD_UNUSED, rand_sample(), rand_idx(), rand_coef());
    filter_item(16'sd12345);
    clear_item();
    filter_item(16'sd0);

    // full length without a clear, so older history still feeds the sum
    wait_quiet();
    set_taps(MAX_TAPS);
    load_item(MAX_TAPS - 1, 18'sh10000);
    load_item(1, -18'sh10000);
    filter_item(16'sd100);
    filter_item(-16'sd200);
    filter_item(16'sh7fff);

    // zero taps behaves as one, oversized count as the maximum
    wait_quiet();
    set_taps(0);
    filter_item(-16'sd1);
    filter_item(16'sh7fff);
    wait_quiet();
    set_taps(127);
    filter_item(16'sh7fff);
    clear_item();
    filter_item(-16'sh8000);

    phase = 0;
    while (n_items < N_ITEMS) begin
      wait_quiet();
      case ($urandom_range(0, 9))
        0:       tc = 0;
        1:       tc = 1;
        2:       tc = MAX_TAPS;
        3:       tc = $urandom_range(MAX_TAPS + 1, 127);
        default: tc = $urandom_range(2, 16);
      endcase
      set_taps(tc);
      calm     <= (phase == 2);
      hold_req <= (phase == 4);
      if ($urandom_range(0, 3) != 0) clear_item();
      repeat ($urandom_range(0, 8)) load_item($urandom_range(0, MAX_TAPS - 1), rand_coef());
      repeat ($urandom_range(20, 60)) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          filter_item(rand_sample());
        end else if (r < 88) begin
          load_item($urandom_range(0, MAX_TAPS - 1), rand_coef());
        end else if (r < 93) begin
          clear_item();
        end else begin
          push_item(CMD_UNUSED, rand_sample(), rand_idx(), rand_coef());
        end
      end
      phase++;
    end

    wait_quiet();
    $display("sent %0d items over %0d tap-count settings (0, 1, 64 and above 64 included)",
             n_items, n_settings);
    $display("compared %0d filter outputs, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
